@@ sv/set_assoc_lru_cache_sim_core_macros.svh @@
// Assertion macros used by the checker file of the cache core.
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SALRU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define SALRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/salru_pkg.sv @@
package salru_pkg;

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 63;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = 32;
    localparam int OUTCOME_W   = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SET_BITS_W  = 3;
    localparam int OFF_BITS_W  = 6;
    localparam int WAYS_W      = 4;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 6'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS = 2'd0,
        CFG_OFF_BITS = 2'd1,
        CFG_WAYS     = 2'd2
    } t_cfg_idx;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_UPDATE = 2'd2
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } t_line;

endpackage

@@ sv/set_assoc_lru_cache_sim_core.sv @@
// An address transferred in the idle state has its set row read into a register; in the
// update state that follows, the result register is loaded once the output register is
// free, and the row is written back.
// One address at a time: the set memory, which holds all ways of a set in one row, is read
// and written back for each address before the next one is taken.
// Reset: control state, counters and configuration are reset, then a sweep over every
// set row clears its valid and recency fields.
module set_assoc_lru_cache_sim_core #(
    parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Address channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [salru_pkg::ADDR_W-1:0]       i_access_address,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [salru_pkg::OUTCOME_W-1:0]    o_outcome,
    output logic [salru_pkg::CNT_W-1:0]        o_hit_total,
    output logic [salru_pkg::CNT_W-1:0]        o_miss_total,
    output logic [salru_pkg::CNT_W-1:0]        o_evict_total
);

    localparam int SET_W   = MAX_SET_BITS;
    localparam int SET_CNT = 1 << MAX_SET_BITS;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_BITS_W_LOCAL = salru_pkg::SET_BITS_W;

    // One memory row holds every way of one set.
    typedef salru_pkg::t_line [MAX_WAYS-1:0] t_row;

    // Configuration registers.
    logic [salru_pkg::SET_BITS_W-1:0] r_set_bits;
    logic [salru_pkg::OFF_BITS_W-1:0] r_off_bits;
    logic [salru_pkg::WAYS_W-1:0]     r_ways;

    // Control.
    salru_pkg::t_state r_state, n_state;
    logic [SET_W-1:0]  r_clr;
    logic              s_clear_we;
    logic              s_rd_en;
    logic              s_commit;
    logic              s_out_free;

    // Set memory and its registered read port.
    t_row              r_mem [SET_CNT];
    t_row              r_rd_row;
    logic              s_wr_en;
    logic [SET_W-1:0]  s_wr_addr;
    t_row              s_wr_row;

    // Address split of the incoming item, held for the update cycle.
    logic [SET_BITS_W_LOCAL-1:0] s_set_bits_eff;
    logic [4:0]                  s_ways_eff;
    logic [SET_W-1:0]            s_set_mask;
    logic [SET_W-1:0]            s_in_set;
    logic [salru_pkg::ADDR_W-1:0] s_off_shift;
    logic [salru_pkg::ADDR_W-1:0] s_tag_shift;
    logic [6:0]                  s_tag_pos;
    logic [salru_pkg::TAG_W-1:0] s_in_tag;
    logic [SET_W-1:0]            r_set;
    logic [salru_pkg::TAG_W-1:0] r_tag;

    // Lookup and update of the set row.
    logic                    s_hit;
    logic [WAY_W-1:0]        s_hit_way;
    logic                    s_empty;
    logic [WAY_W-1:0]        s_empty_way;
    logic [WAY_W-1:0]        s_victim_way;
    logic [salru_pkg::RANK_W-1:0] s_victim_rank;
    logic [WAY_W-1:0]        s_target;
    logic                    s_was_valid;
    logic [salru_pkg::RANK_W-1:0] s_old_rank;
    t_row                    s_new_row;
    salru_pkg::t_outcome     s_outcome;

    // Result register and running totals. The totals only move when a result is
    // loaded, so they always match the result on display.
    logic                    r_out_valid;
    salru_pkg::t_outcome     r_outcome;
    logic [salru_pkg::CNT_W-1:0] r_hit_count;
    logic [salru_pkg::CNT_W-1:0] r_miss_count;
    logic [salru_pkg::CNT_W-1:0] r_evict_count;

    // ------------------------------------------------------------------
    // Configuration writes. An index past the register list is ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= salru_pkg::SET_BITS_RST;
            r_off_bits <= salru_pkg::OFF_BITS_RST;
            r_ways     <= salru_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            unique case (salru_pkg::t_cfg_idx'(i_cfg_idx))
                salru_pkg::CFG_SET_BITS: r_set_bits <= i_cfg_data[salru_pkg::SET_BITS_W-1:0];
                salru_pkg::CFG_OFF_BITS: r_off_bits <= i_cfg_data[salru_pkg::OFF_BITS_W-1:0];
                salru_pkg::CFG_WAYS:     r_ways     <= i_cfg_data[salru_pkg::WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // The set-bit count and the way count are clamped to what the memory holds;
    // zero counts as one in both cases.
    always_comb begin
        if (r_set_bits == '0) begin
            s_set_bits_eff = SET_BITS_W_LOCAL'(1);
        end else if (int'(r_set_bits) > MAX_SET_BITS) begin
            s_set_bits_eff = SET_BITS_W_LOCAL'(MAX_SET_BITS);
        end else begin
            s_set_bits_eff = r_set_bits;
        end
        if (r_ways == '0) begin
            s_ways_eff = 5'd1;
        end else if (int'(r_ways) > MAX_WAYS) begin
            s_ways_eff = 5'(MAX_WAYS);
        end else begin
            s_ways_eff = {1'b0, r_ways};
        end
    end

    // Address split: the set index sits just above the block offset, and the tag
    // is everything above the set index. Bits beyond the top of the address are
    // zero, so a tag that starts at bit 64 or higher is zero.
    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            s_set_mask[i] = (i < int'(s_set_bits_eff));
        end
        s_off_shift = i_access_address >> r_off_bits;
        s_in_set    = s_off_shift[SET_W-1:0] & s_set_mask;
        s_tag_pos   = {1'b0, r_off_bits} + {4'b0, s_set_bits_eff};
        s_tag_shift = i_access_address >> s_tag_pos[5:0];
        s_in_tag    = s_tag_pos[6] ? '0 : s_tag_shift[salru_pkg::TAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: clear sweep after reset, then accept, then read-modify-write.
    // An address is transferred only in the idle state, and the set row is read
    // in the same cycle. The write-back happens in the update state, so a read
    // and a write of the memory never coincide and no forwarding is needed.
    // ------------------------------------------------------------------
    assign s_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            salru_pkg::ST_CLEAR: begin
                if (&r_clr) begin
                    n_state = salru_pkg::ST_IDLE;
                end
            end
            salru_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = salru_pkg::ST_UPDATE;
                end
            end
            salru_pkg::ST_UPDATE: begin
                if (s_out_free) begin
                    n_state = salru_pkg::ST_IDLE;
                end
            end
            default: n_state = salru_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == salru_pkg::ST_IDLE);
        s_rd_en    = (r_state == salru_pkg::ST_IDLE) && i_in_valid;
        s_commit   = (r_state == salru_pkg::ST_UPDATE) && s_out_free;
        s_clear_we = (r_state == salru_pkg::ST_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salru_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (s_clear_we) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rd_en) begin
            r_set <= s_in_set;
            r_tag <= s_in_tag;
        end
    end

    // ------------------------------------------------------------------
    // Set memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    assign s_wr_en   = s_clear_we || s_commit;
    assign s_wr_addr = s_clear_we ? r_clr : r_set;
    assign s_wr_row  = s_clear_we ? t_row'('0) : s_new_row;

    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[s_wr_addr] <= s_wr_row;
        end
        if (s_rd_en) begin
            r_rd_row <= r_mem[s_in_set];
        end
    end

    // ------------------------------------------------------------------
    // Lookup: tag match, first free way and least recently used way, all over
    // the ways in use. Ways beyond the configured count are left untouched.
    // ------------------------------------------------------------------
    always_comb begin
        s_hit       = 1'b0;
        s_hit_way   = '0;
        s_empty     = 1'b0;
        s_empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w < int'(s_ways_eff)) begin
                if (r_rd_row[w].valid && (r_rd_row[w].tag == r_tag)) begin
                    s_hit     = 1'b1;
                    s_hit_way = WAY_W'(w);
                end
                if (!r_rd_row[w].valid) begin
                    s_empty     = 1'b1;
                    s_empty_way = WAY_W'(w);
                end
            end
        end
        // Oldest line wins; on a tie the lower way is kept.
        s_victim_way  = '0;
        s_victim_rank = r_rd_row[0].rank;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if ((w < int'(s_ways_eff)) && (r_rd_row[w].rank > s_victim_rank)) begin
                s_victim_way  = WAY_W'(w);
                s_victim_rank = r_rd_row[w].rank;
            end
        end
    end

    // Recency update: the touched line becomes rank zero. Other valid lines in use
    // that were younger than it age by one, saturating at the top rank; after a fill, all of them age.
    always_comb begin
        if (s_hit) begin
            s_target    = s_hit_way;
            s_was_valid = 1'b1;
            s_outcome   = salru_pkg::OUT_HIT;
        end else if (s_empty) begin
            s_target    = s_empty_way;
            s_was_valid = 1'b0;
            s_outcome   = salru_pkg::OUT_FILL;
        end else begin
            s_target    = s_victim_way;
            s_was_valid = 1'b1;
            s_outcome   = salru_pkg::OUT_EVICT;
        end
        s_old_rank = r_rd_row[s_target].rank;
        s_new_row  = r_rd_row;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if ((WAY_W'(v) != s_target) && (v < int'(s_ways_eff)) && r_rd_row[v].valid
                && (!s_was_valid || (r_rd_row[v].rank < s_old_rank))
                && (r_rd_row[v].rank != salru_pkg::RANK_MAX)) begin
                s_new_row[v].rank = r_rd_row[v].rank + 1'b1;
            end
        end
        s_new_row[s_target].rank  = '0;
        s_new_row[s_target].valid = 1'b1;
        s_new_row[s_target].tag   = r_tag;
    end

    // ------------------------------------------------------------------
    // Result register and saturating totals.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_hit_count   <= '0;
            r_miss_count  <= '0;
            r_evict_count <= '0;
        end else if (s_commit) begin
            r_out_valid <= 1'b1;
            if (s_hit) begin
                if (r_hit_count != salru_pkg::CNT_MAX) begin
                    r_hit_count <= r_hit_count + 1'b1;
                end
            end else begin
                if (r_miss_count != salru_pkg::CNT_MAX) begin
                    r_miss_count <= r_miss_count + 1'b1;
                end
                if (!s_empty && (r_evict_count != salru_pkg::CNT_MAX)) begin
                    r_evict_count <= r_evict_count + 1'b1;
                end
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_commit) begin
            r_outcome <= s_outcome;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_hit_total   = r_hit_count;
    assign o_miss_total  = r_miss_count;
    assign o_evict_total = r_evict_count;

endmodule

@@ sv/salru_chk.sv @@
`include "set_assoc_lru_cache_sim_core_macros.svh"

module salru_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [salru_pkg::OUTCOME_W-1:0]  o_outcome,
    input logic [salru_pkg::CNT_W-1:0]      o_miss_total,
    input logic [salru_pkg::CNT_W-1:0]      o_evict_total
);

    // The clearing sweep keeps the address channel closed right after reset.
    `SALRU_ASSERT_NEXT(a_ready_low_after_reset, !i_rst_n, !o_in_ready, "ready right after reset")

    // A result that is not taken stays on the port.
    `SALRU_ASSERT_NEXT(a_result_held, i_rst_n && o_out_valid && !i_out_ready,
        !i_rst_n || (o_out_valid && $stable(o_outcome) && $stable(o_miss_total)),
        "result changed while stalled")

    // The miss total only moves when a new result is loaded.
    `SALRU_ASSERT_IMP(a_total_moves_with_result,
        $past(i_rst_n) && (o_miss_total != $past(o_miss_total)), o_out_valid,
        "miss total moved without a result")

    // Every eviction is also a miss, and the miss total saturates first.
    `SALRU_ASSERT_IMP(a_evict_le_miss, 1'b1, o_evict_total <= o_miss_total, "more evictions than misses")

endmodule

bind set_assoc_lru_cache_sim_core salru_chk u_salru_chk (.*);
